@@ design/rdq_pkg.sv @@
// Package for the restricted deque: item kind and status codes.
// No dependencies; imported by the deque top level.
`default_nettype none

package rdq_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

@@ design/rdq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rdq_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/restricted_deque.sv @@
// Restricted deque top level: ring of signed words in one slot RAM.
// The result strobe is registered and rises in the cycle after the item is accepted;
// the removed value comes from the slot RAM's registered read port. Throughput: one
// item per cycle, since an item makes at most one slot access and busy stays low.
// Reset: head and count clear, mode becomes input-restricted; slot contents
// stay undefined, with no clearing pass. The receiver cannot stall results.
// Depends on rdq_pkg and rdq_ram.
`default_nettype none

module restricted_deque #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_wdata_i,
  input  wire logic [1:0]                    kind_i,
  input  wire logic                          other_end_i,
  input  wire logic signed [31:0]            value_i,
  output logic                               strobe_o,
  output logic [1:0]                         status_o,
  output logic signed [31:0]                 removed_value_o,
  output logic [$clog2(CAPACITY+1)-1:0]      occupancy_o
);

  import rdq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCnt  = CW'(CAPACITY);
  localparam logic [CW:0]   CapWide = (CW + 1)'(CAPACITY);
  localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);

  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          mode_q;
  logic          strobe_q;
  logic [1:0]    status_q, status_d;
  logic          take_q, take_d;

  logic          accept;
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;

  // The head is below CAPACITY and the offset at most CAPACITY, so one
  // conditional subtract wraps the sum.
  function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] head,
                                             input logic [CW-1:0] offset);
    logic [CW:0] sum;
    sum = (CW + 1)'(head) + (CW + 1)'(offset);
    if (sum >= CapWide) begin
      sum = sum - CapWide;
    end
    return sum[IW-1:0];
  endfunction

  // Every item completes in the cycle after it is taken, so no wait is needed.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    status_d  = STATUS_DONE;
    take_d    = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ring_pos(head_q, count_q);
    ram_raddr = head_q;
    if (accept) begin
      unique case (kind_i)
        KIND_INSERT: begin
          if (count_q == CapCnt) begin
            status_d = STATUS_FULL;
          end else if (!mode_q && other_end_i) begin
            head_d    = (head_q == '0) ? LastIdx : head_q - IW'(1);
            ram_waddr = head_d;
            ram_we    = 1'b1;
            count_d   = count_q + CW'(1);
          end else begin
            ram_we  = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        KIND_REMOVE: begin
          if (count_q == '0) begin
            status_d = STATUS_EMPTY;
          end else if (count_q > CW'(1) && mode_q && other_end_i) begin
            ram_raddr = ring_pos(head_q, count_q - CW'(1));
            ram_re    = 1'b1;
            take_d    = 1'b1;
            count_d   = count_q - CW'(1);
          end else begin
            // Front removal; an emptied ring goes back to position zero.
            ram_re  = 1'b1;
            take_d  = 1'b1;
            count_d = count_q - CW'(1);
            head_d  = (count_q == CW'(1)) ? '0 : ring_pos(head_q, CW'(1));
          end
        end
        KIND_CLEAR: begin
          head_d  = '0;
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  rdq_ram #(
    .Width (32),
    .Depth (CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      mode_q   <= 1'b1;
      strobe_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      strobe_q <= accept;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      take_q   <= take_d;
    end
  end

  assign strobe_o        = strobe_q;
  assign status_o        = status_q;
  assign removed_value_o = take_q ? signed'(ram_rdata) : '0;
  assign occupancy_o     = count_q;

`ifndef SYNTHESIS
  a_result_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> strobe_o)
    else $error("accepted item produced no result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !strobe_o)
    else $error("result without an accepted item");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("element count above capacity");

  a_empty_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == '0))
    else $error("empty ring with nonzero head");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && status_o == STATUS_FULL) |-> (occupancy_o == CapCnt))
    else $error("full status reported below capacity");
`endif

endmodule

`default_nettype wire

@@ tb/tb_restricted_deque.sv @@
// Self-checking testbench for the restricted deque: a directed table, then random
// phases across both modes, checked item by item against table values or a local predictor.
// Depends on rdq_pkg and the restricted_deque top level.
`timescale 1ns / 1ps

module tb_restricted_deque;
  import rdq_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int OCC_W       = $clog2(CAPACITY + 1);
  localparam int HEAD_W      = $clog2(CAPACITY);
  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_ITEMS = 125;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic signed [31:0] removed;
    logic [OCC_W-1:0]  occupancy;
  } deque_result_t;

  typedef struct {
    logic               mode;
    logic [1:0]         kind;
    logic               other;
    logic signed [31:0] value;
    bit                 typed;
    deque_result_t      want;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     cfg_we_i = 1'b0;
  logic                     cfg_wdata_i = 1'b0;
  logic [1:0]               kind_i = KIND_INSERT;
  logic                     other_end_i = 1'b0;
  logic signed [31:0]       value_i = '0;
  logic                     strobe_o;
  logic [1:0]               status_o;
  logic signed [31:0]       removed_value_o;
  logic [OCC_W-1:0]         occupancy_o;

  // Local copy of the deque state and the mode register.
  logic signed [31:0] ring_words [CAPACITY];
  logic [HEAD_W-1:0]  head_q = '0;
  logic [OCC_W-1:0]   count_q = '0;
  logic               input_restricted_q = 1'b1;

  deque_result_t pending_results [$];
  stim_row_t     directed_rows [$];
  int            error_count = 0;
  int            items_sent = 0;
  int            idle_pct = 0;
  int            cycle_count = 0;
  bit            sending = 1'b0;

  restricted_deque #(.CAPACITY(CAPACITY)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .kind_i          (kind_i),
    .other_end_i     (other_end_i),
    .value_i         (value_i),
    .strobe_o        (strobe_o),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .occupancy_o     (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int ring_slot(int offset);
    return (int'(head_q) + offset) % CAPACITY;
  endfunction

  // Applies one item to the local deque and returns the result it should give.
  function automatic deque_result_t predict_deque_op(logic [1:0] k, logic oe,
                                                     logic signed [31:0] v);
    deque_result_t r;
    r.status  = STATUS_DONE;
    r.removed = '0;
    case (k)
      KIND_INSERT: begin
        if (count_q >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else if (!input_restricted_q && oe) begin
          head_q = HEAD_W'(ring_slot(CAPACITY - 1));
          ring_words[head_q] = v;
          count_q++;
        end else begin
          ring_words[ring_slot(int'(count_q))] = v;
          count_q++;
        end
      end
      KIND_REMOVE: begin
        if (count_q == 0) begin
          r.status = STATUS_EMPTY;
        end else if (count_q > 1 && input_restricted_q && oe) begin
          r.removed = ring_words[ring_slot(int'(count_q) - 1)];
          count_q--;
        end else begin
          // The sole element always leaves from the front.
          r.removed = ring_words[head_q];
          head_q = HEAD_W'(ring_slot(1));
          count_q--;
          if (count_q == 0) head_q = '0;
        end
      end
      KIND_CLEAR: begin
        head_q  = '0;
        count_q = '0;
      end
      default: ;
    endcase
    r.occupancy = count_q;
    return r;
  endfunction

  function automatic void add_row(logic m, logic [1:0] k, logic oe, logic signed [31:0] v,
                                  bit typed, logic [1:0] st, logic signed [31:0] rem,
                                  int occ);
    stim_row_t row;
    row.mode  = m;
    row.kind  = k;
    row.other = oe;
    row.value = v;
    row.typed = typed;
    row.want.status    = st;
    row.want.removed   = rem;
    row.want.occupancy = OCC_W'(occ);
    directed_rows.push_back(row);
  endfunction

  task automatic send_item(input logic [1:0] k, input logic oe, input logic signed [31:0] v,
                           input bit typed, input deque_result_t typed_want);
    deque_result_t r;
    start       <= 1'b1;
    sending      = 1'b1;
    kind_i      <= k;
    other_end_i <= oe;
    value_i     <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    r = predict_deque_op(k, oe, v);
    pending_results.push_back(typed ? typed_want : r);
    items_sent++;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start  <= 1'b0;
      sending = 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic lower_start();
    if (sending) begin
      start  <= 1'b0;
      sending = 1'b0;
    end
  endtask

  // The mode register is only written once every item has produced its result.
  task automatic set_mode(input logic m);
    lower_start();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    input_restricted_q = m;
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random(input logic [1:0] k);
    send_item(k, 1'($urandom_range(0, 1)), $urandom, 1'b0, '0);
  endtask

  task automatic run_phase(input logic m, input int pct);
    int target;
    int pick;
    int roll;
    set_mode(m);
    idle_pct = pct;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        // Fill right up, then knock on the full queue a few times.
        while (count_q < CAPACITY) send_random(KIND_INSERT);
        repeat ($urandom_range(1, 3)) send_random(KIND_INSERT);
      end else if (pick < 6) begin
        while (count_q != 0) send_random(KIND_REMOVE);
        repeat ($urandom_range(1, 2)) send_random(KIND_REMOVE);
      end else if (pick < 9) begin
        repeat ($urandom_range(8, 24)) begin
          roll = $urandom_range(0, 99);
          if (roll < 48) send_random(KIND_INSERT);
          else if (roll < 93) send_random(KIND_REMOVE);
          else if (roll < 97) send_random(KIND_CLEAR);
          else send_random(KIND_UNUSED);
        end
      end else begin
        repeat ($urandom_range(4, 8)) send_random(2'($urandom_range(0, 3)));
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    deque_result_t want;
    if (rst_ni && strobe_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d removed %0d occupancy %0d",
                 $time, status_o, removed_value_o, occupancy_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
          error_count++;
        end
        if (removed_value_o !== want.removed) begin
          $display("%0t: removed_value expected %0d, got %0d", $time, want.removed,
                   removed_value_o);
          error_count++;
        end
        if (occupancy_o !== want.occupancy) begin
          $display("%0t: occupancy expected %0d, got %0d", $time, want.occupancy,
                   occupancy_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    // Input-restricted mode, straight out of reset.
    add_row(1'b1, KIND_REMOVE, 1'b0, 32'sd0, 1, STATUS_EMPTY, 32'sd0, 0);
    add_row(1'b1, KIND_REMOVE, 1'b1, 32'sd0, 1, STATUS_EMPTY, 32'sd0, 0);
    add_row(1'b1, KIND_INSERT, 1'b0, 32'sh7fffffff, 1, STATUS_DONE, 32'sd0, 1);
    add_row(1'b1, KIND_INSERT, 1'b1, 32'sh80000000, 1, STATUS_DONE, 32'sd0, 2);
    add_row(1'b1, KIND_INSERT, 1'b0, -32'sd1, 1, STATUS_DONE, 32'sd0, 3);
    add_row(1'b1, KIND_INSERT, 1'b1, 32'sd0, 1, STATUS_DONE, 32'sd0, 4);
    add_row(1'b1, KIND_REMOVE, 1'b1, 32'sd0, 0, STATUS_DONE, 32'sd0, 0);
    add_row(1'b1, KIND_REMOVE, 1'b0, 32'sd0, 0, STATUS_DONE, 32'sd0, 0);
    add_row(1'b1, KIND_UNUSED, 1'b1, 32'sh12345678, 1, STATUS_DONE, 32'sd0, 2);
    add_row(1'b1, KIND_REMOVE, 1'b1, 32'sd0, 0, STATUS_DONE, 32'sd0, 0);
    add_row(1'b1, KIND_REMOVE, 1'b1, 32'sd0, 0, STATUS_DONE, 32'sd0, 0);
    add_row(1'b1, KIND_CLEAR,  1'b0, 32'sd0, 1, STATUS_DONE, 32'sd0, 0);
    add_row(1'b1, KIND_INSERT, 1'b0, 32'sd5, 1, STATUS_DONE, 32'sd0, 1);
    add_row(1'b1, KIND_INSERT, 1'b1, 32'sd6, 1, STATUS_DONE, 32'sd0, 2);
    add_row(1'b1, KIND_CLEAR,  1'b1, 32'sd0, 1, STATUS_DONE, 32'sd0, 0);
    add_row(1'b1, KIND_REMOVE, 1'b0, 32'sd0, 1, STATUS_EMPTY, 32'sd0, 0);
    // Output-restricted mode: front inserts, and the rear request on removal is ignored.
    add_row(1'b0, KIND_INSERT, 1'b1, 32'sd11, 0, STATUS_DONE, 32'sd0, 0);
    add_row(1'b0, KIND_INSERT, 1'b0, 32'sd22, 0, STATUS_DONE, 32'sd0, 0);
    add_row(1'b0, KIND_INSERT, 1'b1, 32'sd33, 0, STATUS_DONE, 32'sd0, 0);
    add_row(1'b0, KIND_REMOVE, 1'b1, 32'sd0, 0, STATUS_DONE, 32'sd0, 0);
    add_row(1'b0, KIND_REMOVE, 1'b0, 32'sd0, 0, STATUS_DONE, 32'sd0, 0);
    add_row(1'b0, KIND_REMOVE, 1'b1, 32'sd0, 0, STATUS_DONE, 32'sd0, 0);
    add_row(1'b0, KIND_REMOVE, 1'b0, 32'sd0, 1, STATUS_EMPTY, 32'sd0, 0);
    add_row(1'b0, KIND_INSERT, 1'b1, 32'sh55555555, 0, STATUS_DONE, 32'sd0, 0);
    add_row(1'b0, KIND_CLEAR,  1'b0, 32'sd0, 1, STATUS_DONE, 32'sd0, 0);
    add_row(1'b0, KIND_UNUSED, 1'b0, 32'shaaaaaaaa, 1, STATUS_DONE, 32'sd0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode != input_restricted_q) set_mode(directed_rows[i].mode);
      send_item(directed_rows[i].kind, directed_rows[i].other, directed_rows[i].value,
                directed_rows[i].typed, directed_rows[i].want);
    end

    run_phase(1'b1, 0);
    run_phase(1'b0, 66);
    run_phase(1'b1, 0);
    run_phase(1'b0, 7);

    lower_start();
    for (int i = 0; i < 100 && pending_results.size() != 0; i++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
